### rtl/bos_pkg.sv
`default_nettype none
package bos_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 12;
  localparam int SCORE_W    = 16;
  localparam int LIMIT_W    = 16;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);

  // Arithmetic widths of the overlap test.
  localparam int DIFF_W  = COORD_BITS + 1;       // signed side length
  localparam int SPAN_W  = COORD_BITS + 2;       // signed clipped-overlap span
  localparam int IW_W    = COORD_BITS + 1;       // unsigned clipped overlap side
  localparam int AREA_W  = 2 * COORD_BITS + 1;   // signed area
  localparam int INTER_W = 2 * COORD_BITS + 1;   // unsigned intersection
  localparam int DEN_W   = 2 * COORD_BITS + 3;   // signed denominator
  localparam int MUL_A_W = DEN_W;
  localparam int MUL_B_W = (COORD_BITS + 2 > LIMIT_W + 1) ? COORD_BITS + 2 : LIMIT_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_MODE  = 1'b1;

  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_MIN   = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'h8000;

  typedef struct packed {
    logic [COORD_BITS-1:0] l;
    logic [COORD_BITS-1:0] t;
    logic [COORD_BITS-1:0] r;
    logic [COORD_BITS-1:0] b;
  } bos_box_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    bos_box_t         wr_box;
    logic [SCORE_W-1:0] wr_score;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } bos_mem_req_t;

endpackage
`default_nettype wire

### rtl/box_overlap_suppression.sv
`default_nettype none
// Greedy overlap suppression over a set of up to MAX_BOXES detection boxes.
// Load: one box beat per cycle on the in_ ports, taken at an edge where start
// is high and busy is low. A box beyond capacity is dropped and the set is
// flagged as overflowed. A beat with in_last_box high starts processing.
// Processing: the block repeatedly scans the live boxes for the best score,
// reads the winner back and forms its area, then tests every live box
// against it with one shared registered multiplier: it reads the box, forms
// the intersection, the box's area and the denominator, multiplies the
// denominator by the limit and compares. Dead boxes are skipped.
// Results: n beats, one per cycle in load order, each shown for one cycle
// with out_valid high; out_last_result marks the final one. The receiver
// cannot stall. busy stays high from the cycle after the last box until the
// last result is registered.
// Configuration writes on cfg_ are taken at any edge with cfg_we high and
// must only be made while the block is idle.
// Reset (synchronous, rst_n low) empties the set, restores overlap_limit to
// one half and overlap_mode to union. The box memory needs no clearing.
module box_overlap_suppression
  import bos_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] in_left,
  input  wire logic [COORD_BITS-1:0] in_top,
  input  wire logic [COORD_BITS-1:0] in_right,
  input  wire logic [COORD_BITS-1:0] in_bottom,
  input  wire logic [SCORE_W-1:0]    in_score_in,
  input  wire logic                  in_last_box,
  output logic                       out_valid,
  output logic [IDX_W-1:0]           out_box_index,
  output logic                       out_keep,
  output logic                       out_overflow,
  output logic                       out_last_result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE       = 4'd0;
  localparam logic [ST_W-1:0] ST_SEL        = 4'd1;
  localparam logic [ST_W-1:0] ST_SEL_CMP    = 4'd2;
  localparam logic [ST_W-1:0] ST_BEST_RD    = 4'd3;
  localparam logic [ST_W-1:0] ST_BEST_AREA  = 4'd4;
  localparam logic [ST_W-1:0] ST_SUP        = 4'd5;
  localparam logic [ST_W-1:0] ST_SUP_INTER  = 4'd6;
  localparam logic [ST_W-1:0] ST_SUP_AREA   = 4'd7;
  localparam logic [ST_W-1:0] ST_SUP_DEN    = 4'd8;
  localparam logic [ST_W-1:0] ST_SUP_MUL    = 4'd9;
  localparam logic [ST_W-1:0] ST_SUP_CMP    = 4'd10;
  localparam logic [ST_W-1:0] ST_OUT        = 4'd11;

  logic [ST_W-1:0]      state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MAX_BOXES-1:0] alive_r, alive_nxt;
  logic [MAX_BOXES-1:0] kept_r, kept_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_r, best_nxt;
  logic [SCORE_W-1:0]   best_score_r, best_score_nxt;
  bos_box_t             bbox_r, bbox_nxt;
  logic signed [AREA_W-1:0] abest_r, abest_nxt;
  logic [INTER_W-1:0]   inter_r, inter_nxt;
  logic signed [DEN_W-1:0] denom_r, denom_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic                 mode_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic                 out_keep_r, out_keep_nxt;
  logic                 out_ovf_r, out_ovf_nxt;
  logic                 out_last_r, out_last_nxt;

  bos_mem_req_t         mem_req;
  bos_box_t             rd_box;
  logic [SCORE_W-1:0]   rd_score;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  bos_store u_store (
    .clk        (clk),
    .req        (mem_req),
    .rd_box_r   (rd_box),
    .rd_score_r (rd_score)
  );

  bos_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  // Geometry of the box held in the read register against the selected box.
  logic [COORD_BITS-1:0]    min_r, max_l, min_b, max_t;
  logic signed [SPAN_W-1:0] span_w, span_h;
  logic [IW_W-1:0]          iw, ih;
  logic signed [DIFF_W-1:0] cur_w, cur_h, bst_w, bst_h;
  logic signed [AREA_W-1:0] cur_area;
  logic signed [DEN_W-1:0]  ext_cur, ext_best, ext_inter, union_den, min_den;
  logic [PROD_W-1:0]        inter_shift;
  logic                     suppress;

  always_comb begin
    min_r  = (rd_box.r < bbox_r.r) ? rd_box.r : bbox_r.r;
    max_l  = (rd_box.l > bbox_r.l) ? rd_box.l : bbox_r.l;
    min_b  = (rd_box.b < bbox_r.b) ? rd_box.b : bbox_r.b;
    max_t  = (rd_box.t > bbox_r.t) ? rd_box.t : bbox_r.t;
    span_w = $signed({2'b00, min_r}) - $signed({2'b00, max_l}) + SPAN_W'(1);
    span_h = $signed({2'b00, min_b}) - $signed({2'b00, max_t}) + SPAN_W'(1);
    iw     = span_w[SPAN_W-1] ? '0 : span_w[IW_W-1:0];
    ih     = span_h[SPAN_W-1] ? '0 : span_h[IW_W-1:0];
    cur_w  = $signed({1'b0, rd_box.r}) - $signed({1'b0, rd_box.l});
    cur_h  = $signed({1'b0, rd_box.b}) - $signed({1'b0, rd_box.t});
    bst_w  = $signed({1'b0, rd_box.r}) - $signed({1'b0, rd_box.l});
    bst_h  = $signed({1'b0, rd_box.b}) - $signed({1'b0, rd_box.t});
    cur_area  = prod[AREA_W-1:0];
    ext_cur   = {{(DEN_W-AREA_W){cur_area[AREA_W-1]}}, cur_area};
    ext_best  = {{(DEN_W-AREA_W){abest_r[AREA_W-1]}}, abest_r};
    ext_inter = {{(DEN_W-INTER_W){1'b0}}, inter_r};
    union_den = ext_cur + ext_best - ext_inter;
    min_den   = (ext_cur < ext_best) ? ext_cur : ext_best;
    inter_shift = PROD_W'({inter_r, {LIMIT_W{1'b0}}});
    // A denominator at or below zero suppresses on any intersection at all.
    if (denom_r[DEN_W-1] || (denom_r == '0)) begin
      suppress = (inter_r != '0);
    end else begin
      suppress = inter_shift > $unsigned(prod);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    ovf_nxt        = ovf_r;
    alive_nxt      = alive_r;
    kept_nxt       = kept_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_score_nxt = best_score_r;
    bbox_nxt       = bbox_r;
    abest_nxt      = abest_r;
    inter_nxt      = inter_r;
    denom_nxt      = denom_r;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_keep_nxt   = out_keep_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    mem_req.wr_en    = 1'b0;
    mem_req.wr_addr  = count_r[IDX_W-1:0];
    mem_req.wr_box   = '{l: in_left, t: in_top, r: in_right, b: in_bottom};
    mem_req.wr_score = in_score_in;
    mem_req.rd_en    = 1'b0;
    mem_req.rd_addr  = scan_r[IDX_W-1:0];
    mul_a = '0;
    mul_b = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (count_r < CNT_W'(MAX_BOXES)) begin
            mem_req.wr_en = 1'b1;
            alive_nxt[count_r[IDX_W-1:0]] = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_box) begin
            scan_nxt  = '0;
            found_nxt = 1'b0;
            if (count_nxt == '0) begin
              ovf_nxt = 1'b0;
            end else begin
              state_nxt = ST_SEL;
            end
          end
        end
      end
      ST_SEL: begin
        if (scan_r == count_r) begin
          scan_nxt = '0;
          if (found_r) begin
            kept_nxt[best_r]  = 1'b1;
            alive_nxt[best_r] = 1'b0;
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr   = best_r;
            state_nxt         = ST_BEST_RD;
          end else begin
            state_nxt = ST_OUT;
          end
        end else if (alive_r[scan_r[IDX_W-1:0]]) begin
          mem_req.rd_en = 1'b1;
          state_nxt     = ST_SEL_CMP;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      ST_SEL_CMP: begin
        // Strictly greater, so an equal score keeps the earlier box.
        if (!found_r || (rd_score > best_score_r)) begin
          found_nxt      = 1'b1;
          best_nxt       = scan_r[IDX_W-1:0];
          best_score_nxt = rd_score;
        end
        scan_nxt  = scan_r + CNT_W'(1);
        state_nxt = ST_SEL;
      end
      ST_BEST_RD: begin
        bbox_nxt  = rd_box;
        mul_a     = {{(MUL_A_W-DIFF_W){bst_w[DIFF_W-1]}}, bst_w};
        mul_b     = {{(MUL_B_W-DIFF_W){bst_h[DIFF_W-1]}}, bst_h};
        state_nxt = ST_BEST_AREA;
      end
      ST_BEST_AREA: begin
        abest_nxt = prod[AREA_W-1:0];
        state_nxt = ST_SUP;
      end
      ST_SUP: begin
        if (scan_r == count_r) begin
          scan_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SEL;
        end else if (alive_r[scan_r[IDX_W-1:0]]) begin
          mem_req.rd_en = 1'b1;
          state_nxt     = ST_SUP_INTER;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      ST_SUP_INTER: begin
        mul_a     = {{(MUL_A_W-IW_W){1'b0}}, iw};
        mul_b     = {{(MUL_B_W-IW_W){1'b0}}, ih};
        state_nxt = ST_SUP_AREA;
      end
      ST_SUP_AREA: begin
        inter_nxt = prod[INTER_W-1:0];
        mul_a     = {{(MUL_A_W-DIFF_W){cur_w[DIFF_W-1]}}, cur_w};
        mul_b     = {{(MUL_B_W-DIFF_W){cur_h[DIFF_W-1]}}, cur_h};
        state_nxt = ST_SUP_DEN;
      end
      ST_SUP_DEN: begin
        denom_nxt = (mode_r == MODE_MIN) ? min_den : union_den;
        state_nxt = ST_SUP_MUL;
      end
      ST_SUP_MUL: begin
        mul_a     = denom_r;
        mul_b     = {{(MUL_B_W-LIMIT_W){1'b0}}, limit_r};
        state_nxt = ST_SUP_CMP;
      end
      ST_SUP_CMP: begin
        if (suppress) begin
          alive_nxt[scan_r[IDX_W-1:0]] = 1'b0;
        end
        scan_nxt  = scan_r + CNT_W'(1);
        state_nxt = ST_SUP;
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = scan_r[IDX_W-1:0];
        out_keep_nxt  = kept_r[scan_r[IDX_W-1:0]];
        out_ovf_nxt   = ovf_r;
        out_last_nxt  = (scan_r + CNT_W'(1) == count_r);
        scan_nxt      = scan_r + CNT_W'(1);
        if (scan_r + CNT_W'(1) == count_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          alive_nxt = '0;
          kept_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      ovf_r       <= 1'b0;
      alive_r     <= '0;
      kept_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      ovf_r       <= ovf_nxt;
      alive_r     <= alive_nxt;
      kept_r      <= kept_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r       <= best_nxt;
    best_score_r <= best_score_nxt;
    bbox_r       <= bbox_nxt;
    abest_r      <= abest_nxt;
    inter_r      <= inter_nxt;
    denom_r      <= denom_nxt;
    out_idx_r    <= out_idx_nxt;
    out_keep_r   <= out_keep_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      mode_r  <= MODE_UNION;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERLAP_LIMIT: limit_r <= cfg_wdata;
        REG_OVERLAP_MODE:  mode_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_box_index   = out_idx_r;
  assign out_keep        = out_keep_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_result = out_last_r;

endmodule
`default_nettype wire

### rtl/bos_mul.sv
`default_nettype none
module bos_mul
  import bos_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [MUL_A_W-1:0] mul_a,
  input  wire logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [PROD_W-1:0]       prod_r
);

  // The product is registered; the sequencer picks it up in the cycle after it drives the operands.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule
`default_nettype wire

### rtl/bos_store.sv
`default_nettype none
module bos_store
  import bos_pkg::*;
(
  input  wire logic         clk,
  input  wire bos_mem_req_t req,
  output bos_box_t          rd_box_r,
  output logic [SCORE_W-1:0] rd_score_r
);

  bos_box_t           box_mem   [MAX_BOXES];
  logic [SCORE_W-1:0] score_mem [MAX_BOXES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      box_mem[req.wr_addr]   <= req.wr_box;
      score_mem[req.wr_addr] <= req.wr_score;
    end
  end

  // Read data holds until the next read, so the sequencer can keep using it
  // until it issues another read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_box_r   <= box_mem[req.rd_addr];
      rd_score_r <= score_mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

### tb/box_overlap_suppression_tb.sv
`default_nettype none
module box_overlap_suppression_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bos_pkg::*;

  localparam int STALL_LIMIT   = 150000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 460;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

  typedef struct packed {
    bos_box_t           corners;
    logic [SCORE_W-1:0] score;
    logic               last;
  } box_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] box_no;
    logic             keep;
    logic             overflow;
    logic             last;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_BITS-1:0] in_left = '0;
  logic [COORD_BITS-1:0] in_top = '0;
  logic [COORD_BITS-1:0] in_right = '0;
  logic [COORD_BITS-1:0] in_bottom = '0;
  logic [SCORE_W-1:0]    in_score_in = '0;
  logic                  in_last_box = 1'b0;
  logic                  out_valid;
  logic [IDX_W-1:0]      out_box_index;
  logic                  out_keep;
  logic                  out_overflow;
  logic                  out_last_result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_OVERLAP_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  box_beat_t pending_boxes [$];
  verdict_t  expected_verdicts [$];

  // Predictor state: the set being loaded and the configuration it sees.
  bos_box_t           set_corners [$];
  logic [SCORE_W-1:0] set_scores [$];
  logic               set_overflow = 1'b0;
  logic [LIMIT_W-1:0] limit_q16 = LIMIT_RESET;
  logic               ratio_mode = MODE_UNION;

  logic beat_taken = 1'b0;
  int   beats_sent = 0;
  int   fail_count = 0;
  int   stall_cycles = 0;

  box_overlap_suppression dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_left         (in_left),
    .in_top          (in_top),
    .in_right        (in_right),
    .in_bottom       (in_bottom),
    .in_score_in     (in_score_in),
    .in_last_box     (in_last_box),
    .out_valid       (out_valid),
    .out_box_index   (out_box_index),
    .out_keep        (out_keep),
    .out_overflow    (out_overflow),
    .out_last_result (out_last_result),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void log_failure(string msg);
    if (fail_count < 10) begin
      $display("%s", msg);
    end
    fail_count++;
  endfunction

  function automatic logic [COORD_BITS-1:0] clip_coord(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > COORD_MAX) begin
      return '1;
    end
    return v[COORD_BITS-1:0];
  endfunction

  function automatic void queue_box(logic [COORD_BITS-1:0] l, logic [COORD_BITS-1:0] t,
                                    logic [COORD_BITS-1:0] r, logic [COORD_BITS-1:0] b,
                                    logic [SCORE_W-1:0] score, logic last);
    box_beat_t beat;
    beat.corners.l = l;
    beat.corners.t = t;
    beat.corners.r = r;
    beat.corners.b = b;
    beat.score = score;
    beat.last = last;
    pending_boxes.insert(pending_boxes.size(), beat);
  endfunction

  // Greedy suppression over the loaded set; queues one verdict per stored box
  // in load order and empties the set.
  function automatic void resolve_set();
    bit       alive [MAX_BOXES];
    bit       kept [MAX_BOXES];
    int       n;
    int       best;
    bit       searching;
    bos_box_t a;
    bos_box_t b;
    longint   iw;
    longint   ih;
    longint   inter;
    longint   area_a;
    longint   area_b;
    longint   denom;
    bit       hit;
    n = set_corners.size();
    for (int i = 0; i < n; i++) begin
      alive[i] = 1'b1;
      kept[i] = 1'b0;
    end
    searching = 1'b1;
    while (searching) begin
      best = -1;
      // Strict compare keeps the earliest box among equal scores.
      for (int i = 0; i < n; i++) begin
        if (alive[i] && (best < 0 || set_scores[i] > set_scores[best])) begin
          best = i;
        end
      end
      if (best < 0) begin
        searching = 1'b0;
      end else begin
        kept[best] = 1'b1;
        alive[best] = 1'b0;
        b = set_corners[best];
        for (int i = 0; i < n; i++) begin
          if (alive[i]) begin
            a = set_corners[i];
            iw = longint'(a.r < b.r ? a.r : b.r) - longint'(a.l > b.l ? a.l : b.l) + 1;
            ih = longint'(a.b < b.b ? a.b : b.b) - longint'(a.t > b.t ? a.t : b.t) + 1;
            if (iw < 0) begin
              iw = 0;
            end
            if (ih < 0) begin
              ih = 0;
            end
            inter = iw * ih;
            area_a = (longint'(a.r) - longint'(a.l)) * (longint'(a.b) - longint'(a.t));
            area_b = (longint'(b.r) - longint'(b.l)) * (longint'(b.b) - longint'(b.t));
            if (ratio_mode == MODE_UNION) begin
              denom = area_a + area_b - inter;
            end else begin
              denom = (area_a < area_b) ? area_a : area_b;
            end
            // A denominator that is not positive suppresses on any intersection.
            if (denom <= 0) begin
              hit = (inter > 0);
            end else begin
              hit = (inter * 65536 > longint'(limit_q16) * denom);
            end
            if (hit) begin
              alive[i] = 1'b0;
            end
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      expected_verdicts.insert(expected_verdicts.size(),
                               '{box_no: IDX_W'(k), keep: kept[k],
                                 overflow: set_overflow, last: (k == n - 1)});
    end
    set_corners.delete();
    set_scores.delete();
    set_overflow = 1'b0;
  endfunction

  task automatic settle();
    while (pending_boxes.size() != 0 || start || expected_verdicts.size() != 0 || busy) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Box driver: a beat stays on the ports until it is taken.
  always @(negedge clk) begin : drive
    box_beat_t nxt;
    if (rst_n && (!start || beat_taken)) begin
      if (pending_boxes.size() != 0 &&
          ((beats_sent >= 150 && beats_sent < 270) || $urandom_range(99) >= 34)) begin
        nxt = pending_boxes.pop_front();
        start <= 1'b1;
        in_left <= nxt.corners.l;
        in_top <= nxt.corners.t;
        in_right <= nxt.corners.r;
        in_bottom <= nxt.corners.b;
        in_score_in <= nxt.score;
        in_last_box <= nxt.last;
        beats_sent <= beats_sent + 1;
      end else begin
        start <= 1'b0;
        in_left <= COORD_BITS'($urandom);
        in_top <= COORD_BITS'($urandom);
        in_right <= COORD_BITS'($urandom);
        in_bottom <= COORD_BITS'($urandom);
        in_score_in <= SCORE_W'($urandom);
        in_last_box <= 1'($urandom);
      end
    end
  end

  always @(posedge clk) begin : observe
    verdict_t got;
    verdict_t want;
    bos_box_t bx;
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          REG_OVERLAP_LIMIT: limit_q16 = cfg_wdata[LIMIT_W-1:0];
          REG_OVERLAP_MODE:  ratio_mode = cfg_wdata[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (set_corners.size() < MAX_BOXES) begin
          bx.l = in_left;
          bx.t = in_top;
          bx.r = in_right;
          bx.b = in_bottom;
          set_corners.insert(set_corners.size(), bx);
          set_scores.insert(set_scores.size(), in_score_in);
        end else begin
          set_overflow = 1'b1;
        end
        if (in_last_box) begin
          resolve_set();
        end
      end
      if (out_valid) begin
        got = '{box_no: out_box_index, keep: out_keep, overflow: out_overflow,
                last: out_last_result};
        if (expected_verdicts.size() == 0) begin
          log_failure($sformatf("unexpected result: box %0d keep %0d overflow %0d last %0d",
                                got.box_no, got.keep, got.overflow, got.last));
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            log_failure($sformatf(
              "mismatch: expected box %0d keep %0d overflow %0d last %0d, got %0d %0d %0d %0d",
              want.box_no, want.keep, want.overflow, want.last,
              got.box_no, got.keep, got.overflow, got.last));
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int                    set_no;
    int                    phase_no;
    int                    random_items;
    int                    count;
    int                    nclus;
    int                    c;
    int                    w;
    int                    h;
    int                    x0;
    int                    y0;
    int                    cx [3];
    int                    cy [3];
    logic [LIMIT_W-1:0]    lim;
    logic                  mode;
    logic [SCORE_W-1:0]    score;
    logic [COORD_BITS-1:0] l;
    logic [COORD_BITS-1:0] t;
    logic [COORD_BITS-1:0] r;
    logic [COORD_BITS-1:0] b;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets under the reset configuration.
    queue_box(0, 0, 0, 0, 0, 1'b1);
    queue_box(0, 0, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b0);
    queue_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 1'b1);
    // Identical boxes with equal scores: the earlier one must win.
    queue_box(10, 10, 50, 50, 1000, 1'b0);
    queue_box(10, 10, 50, 50, 1000, 1'b1);
    // Corners that touch give a one-pixel intersection.
    queue_box(0, 0, 10, 10, 7, 1'b0);
    queue_box(10, 10, 20, 20, 9, 1'b1);
    // Two coincident points: negative union, suppressed on intersection.
    queue_box(5, 5, 5, 5, 3, 1'b0);
    queue_box(5, 5, 5, 5, 3, 1'b1);
    // Inverted box, a full box, and a zero-width line inside it.
    queue_box(20, 10, 10, 30, 500, 1'b0);
    queue_box(0, 0, 40, 40, 400, 1'b0);
    queue_box(10, 10, 10, 30, 450, 1'b1);
    queue_box(100, 100, 200, 200, 200, 1'b0);
    queue_box(300, 300, 400, 400, 300, 1'b0);
    queue_box(105, 100, 205, 200, 100, 1'b1);
    queue_box(COORD_MAX, COORD_MAX, 0, 0, 1, 1'b0);
    queue_box(0, 0, COORD_MAX, COORD_MAX, 2, 1'b1);

    set_no = 0;
    phase_no = 0;
    random_items = 0;
    score = '0;
    while (random_items < RANDOM_ITEMS) begin
      if (set_no % 8 == 0) begin
        settle();
        case (phase_no)
          0: begin lim = '0; mode = MODE_MIN; end
          1: begin lim = '1; mode = MODE_UNION; end
          2: begin lim = '1; mode = MODE_MIN; end
          3: begin lim = '0; mode = MODE_UNION; end
          default: begin
            lim = LIMIT_W'($urandom_range(0, 65535));
            mode = 1'($urandom_range(0, 1));
          end
        endcase
        phase_no++;
        cfg_we <= 1'b1;
        cfg_index <= REG_OVERLAP_LIMIT;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_index <= REG_OVERLAP_MODE;
        cfg_wdata <= {(CFG_DATA_W-1)'($urandom), mode};
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      // A full store, then two sets that overflow it.
      if (set_no == 3) begin
        count = MAX_BOXES;
      end else if (set_no == 13) begin
        count = MAX_BOXES + 1;
      end else if (set_no == 25) begin
        count = MAX_BOXES + 3;
      end else begin
        count = $urandom_range(1, 10);
      end
      random_items += count;
      set_no++;
      nclus = $urandom_range(1, 3);
      for (int k = 0; k < nclus; k++) begin
        cx[k] = $urandom_range(0, COORD_MAX);
        cy[k] = $urandom_range(0, COORD_MAX);
      end
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(99) < 80) begin
          // Boxes jittered around a few centers so that many of them overlap.
          c = $urandom_range(0, nclus - 1);
          w = $urandom_range(0, 300);
          h = $urandom_range(0, 300);
          x0 = cx[c] + int'($urandom_range(0, 40)) - 20 - w / 2;
          y0 = cy[c] + int'($urandom_range(0, 40)) - 20 - h / 2;
          l = clip_coord(x0);
          r = clip_coord(x0 + w);
          t = clip_coord(y0);
          b = clip_coord(y0 + h);
        end else begin
          l = COORD_BITS'($urandom);
          t = COORD_BITS'($urandom);
          r = COORD_BITS'($urandom);
          b = COORD_BITS'($urandom);
        end
        if (i == 0 || $urandom_range(99) >= 25) begin
          score = SCORE_W'($urandom);
        end
        queue_box(l, t, r, b, score, i == count - 1);
      end
    end
    settle();
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
